// ----- hdl/wwdt_pkg.sv -----
// Shared types and constants for the windowed watchdog timer.
package wwdt_pkg;

  localparam int DLY_W  = 40;  // widest decoded delay: 27-bit frequency << 13
  localparam int CORE_W = 27;
  localparam int WDT_W  = 20;
  localparam int FUSE_W = 8;
  localparam int CFG_W  = 27;
  localparam int STEP_W = $clog2(DLY_W);

  localparam logic [3:0] LAST_CODE  = 4'd11;
  localparam logic [3:0] CODE_SHIFT = 4'd2;

  localparam logic [1:0] CFG_FUSE = 2'd0;
  localparam logic [1:0] CFG_CORE = 2'd1;
  localparam logic [1:0] CFG_WDT  = 2'd2;

  typedef enum logic [2:0] {
    FUNC_TICK    = 3'd0,
    FUNC_WR_CTRL = 3'd1,
    FUNC_WR_STAT = 3'd2,
    FUNC_CLEAR   = 3'd3,
    FUNC_RD_CTRL = 3'd4,
    FUNC_RD_STAT = 3'd5,
    FUNC_RESET   = 3'd6
  } func_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV_P,
    ST_DIV_W,
    ST_EXEC
  } state_e;

  typedef struct packed {
    logic capture;    // latch the incoming item
    logic use_held;   // work on the latched item instead of the live one
    logic exec;       // apply the step and load the output register
    logic div_start;
    logic div_win;    // divider works on the window code
    logic save_p;
    logic save_w;
  } dp_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_busy;
    logic out_free;
  } dp_status_t;

endpackage

// ----- hdl/wwdt_div.sv -----
// Bit-serial divider: (core_freq << (code+2)) / wdt_freq, one quotient bit a cycle.
module wwdt_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [3:0]                    code_i,
  input  logic [wwdt_pkg::CORE_W-1:0]   core_i,
  input  logic [wwdt_pkg::WDT_W-1:0]    wdt_i,
  output logic                          busy_o,
  output logic [wwdt_pkg::DLY_W-1:0]    quot_o
);

  logic                          busy_q, busy_d;
  logic [wwdt_pkg::STEP_W-1:0]   step_q, step_d;
  logic [wwdt_pkg::DLY_W-1:0]    quo_q, quo_d;
  logic [wwdt_pkg::WDT_W-1:0]    rem_q, rem_d;
  logic [wwdt_pkg::WDT_W-1:0]    den_q, den_d;
  logic [wwdt_pkg::WDT_W:0]      trial;
  logic                          code_off;

  assign code_off = (code_i == 4'd0) || (code_i > wwdt_pkg::LAST_CODE);
  // remainder stays below the divisor, so it always fits the divisor width
  assign trial    = {rem_q, quo_q[wwdt_pkg::DLY_W-1]};

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    den_d  = den_q;
    if (start_i) begin
      step_d = '0;
      rem_d  = '0;
      den_d  = (wdt_i == '0) ? wwdt_pkg::WDT_W'(1) : wdt_i;
      if (code_off) begin
        busy_d = 1'b0;
        quo_d  = '0;
      end else begin
        busy_d = 1'b1;
        quo_d  = wwdt_pkg::DLY_W'(core_i) << (code_i + wwdt_pkg::CODE_SHIFT);
      end
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_d = wwdt_pkg::WDT_W'(trial - {1'b0, den_q});
        quo_d = {quo_q[wwdt_pkg::DLY_W-2:0], 1'b1};
      end else begin
        rem_d = trial[wwdt_pkg::WDT_W-1:0];
        quo_d = {quo_q[wwdt_pkg::DLY_W-2:0], 1'b0};
      end
      step_d = step_q + wwdt_pkg::STEP_W'(1);
      if (step_q == wwdt_pkg::STEP_W'(wwdt_pkg::DLY_W - 1)) begin
        busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    den_q <= den_d;
  end

  assign busy_o = busy_q;
  assign quot_o = quo_q;

endmodule

// ----- hdl/wwdt_dp.sv -----
// Datapath: configuration, watchdog state, delay cache, divider and output register.
module wwdt_dp #(
  parameter int COUNT_WIDTH = 32,
  parameter int SYNC_TICKS  = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [wwdt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic [2:0]                  func_i,
  input  logic [7:0]                  wdata_i,
  input  logic                        m_tready_i,
  input  wwdt_pkg::dp_cmd_t           cmd_i,
  output wwdt_pkg::dp_status_t        status_o,
  output logic                        m_tvalid_o,
  output logic [7:0]                  rd_data_o,
  output logic                        rst_req_o
);

  localparam int SYNC_W = $clog2(SYNC_TICKS + 1);
  localparam int SUM_W  = (COUNT_WIDTH > wwdt_pkg::DLY_W + 1) ? COUNT_WIDTH
                                                               : wwdt_pkg::DLY_W + 1;

  // configuration
  logic [wwdt_pkg::FUSE_W-1:0] fuse_q;
  logic [wwdt_pkg::CORE_W-1:0] core_q;
  logic [wwdt_pkg::WDT_W-1:0]  wdt_q;

  // watchdog state
  logic [7:0]             ctrl_q, ctrl_d;
  logic                   lock_q, lock_d;
  logic [COUNT_WIDTH-1:0] cd_q, cd_d;
  logic                   run_q, run_d;
  logic [SYNC_W-1:0]      sync_q, sync_d;
  logic                   first_q, first_d;

  // decoded delays of the current control byte
  logic [wwdt_pkg::DLY_W-1:0] period_q, window_q;
  logic                       cache_ok_q;

  logic [2:0] held_func_q;
  logic [7:0] held_data_q;

  logic       out_valid_q;
  logic [7:0] out_rd_q, rd_d;
  logic       out_req_q, req_d;

  logic                       div_busy;
  logic [wwdt_pkg::DLY_W-1:0] div_quot;

  wwdt_pkg::func_e  live_func, func;
  logic [7:0]       data, src;
  logic [3:0]       div_code;

  logic [SUM_W-1:0]       sum_w, cnt_max;
  logic [COUNT_WIDTH-1:0] sum_sat;
  logic [COUNT_WIDTH-1:0] cd_a, left;
  logic                   run_a;
  logic [SYNC_W-1:0]      sync_n;
  logic                   trip;

  assign live_func = wwdt_pkg::func_e'(func_i);
  assign func      = cmd_i.use_held ? wwdt_pkg::func_e'(held_func_q) : live_func;
  assign data      = cmd_i.use_held ? held_data_q : wdata_i;

  // byte whose codes are decoded: the new control value, the fuse byte, or the current one
  always_comb begin
    case (func)
      wwdt_pkg::FUNC_WR_CTRL: src = data;
      wwdt_pkg::FUNC_RESET:   src = fuse_q;
      default:                src = ctrl_q;
    endcase
  end

  assign div_code = cmd_i.div_win ? src[7:4] : src[3:0];

  wwdt_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.div_start),
    .code_i  (div_code),
    .core_i  (core_q),
    .wdt_i   (wdt_q),
    .busy_o  (div_busy),
    .quot_o  (div_quot)
  );

  always_comb begin
    status_o.div_busy = div_busy;
    status_o.out_free = !out_valid_q || m_tready_i;
    case (live_func)
      wwdt_pkg::FUNC_WR_CTRL: status_o.need_div = !lock_q;
      wwdt_pkg::FUNC_RESET:   status_o.need_div = 1'b1;
      wwdt_pkg::FUNC_TICK:    status_o.need_div = (sync_q == SYNC_W'(1)) && !cache_ok_q;
      default:                status_o.need_div = 1'b0;
    endcase
  end

  // period + window, saturated to the counter width
  assign sum_w   = SUM_W'(period_q) + SUM_W'(window_q);
  assign cnt_max = SUM_W'({COUNT_WIDTH{1'b1}});
  assign sum_sat = (sum_w > cnt_max) ? {COUNT_WIDTH{1'b1}} : sum_w[COUNT_WIDTH-1:0];

  // tick: the countdown steps first, then the clear sync
  always_comb begin
    cd_a  = cd_q;
    run_a = run_q;
    if (run_q && (cd_q != '0)) begin
      cd_a = cd_q - COUNT_WIDTH'(1);
    end
    if (run_q && (cd_a == '0)) begin
      run_a = 1'b0;
    end
    sync_n = sync_q - SYNC_W'(1);
    left   = run_a ? cd_a : '0;
    trip   = (window_q != '0) && (SUM_W'(left) > SUM_W'(period_q)) && !first_q;
  end

  always_comb begin
    ctrl_d  = ctrl_q;
    lock_d  = lock_q;
    cd_d    = cd_q;
    run_d   = run_q;
    sync_d  = sync_q;
    first_d = first_q;
    rd_d    = 8'd0;
    req_d   = 1'b0;
    case (func)
      wwdt_pkg::FUNC_TICK: begin
        cd_d  = cd_a;
        run_d = run_a;
        req_d = run_q && (cd_a == '0);
        if (sync_q != '0) begin
          sync_d = sync_n;
          if (sync_n == '0) begin
            if (trip) begin
              req_d = 1'b1;
            end else begin
              cd_d    = sum_sat;
              run_d   = (sum_sat != '0);
              first_d = 1'b0;
            end
          end
        end
      end
      wwdt_pkg::FUNC_WR_CTRL: begin
        if (!lock_q) begin
          ctrl_d = data;
          if (period_q != '0) begin
            if (!run_q) begin
              first_d = 1'b1;
            end
            cd_d  = sum_sat;
            run_d = 1'b1;
          end else begin
            cd_d  = '0;
            run_d = 1'b0;
          end
        end
      end
      wwdt_pkg::FUNC_WR_STAT: begin
        if (data[0]) begin
          lock_d = 1'b1;
        end
      end
      wwdt_pkg::FUNC_CLEAR: begin
        if ((ctrl_q[3:0] != 4'd0) && (sync_q == '0)) begin
          sync_d = SYNC_W'(SYNC_TICKS);
        end
      end
      wwdt_pkg::FUNC_RD_CTRL: rd_d = ctrl_q;
      wwdt_pkg::FUNC_RD_STAT: rd_d = {7'd0, lock_q};
      wwdt_pkg::FUNC_RESET: begin
        ctrl_d  = fuse_q;
        sync_d  = '0;
        first_d = 1'b1;
        lock_d  = (fuse_q[3:0] != 4'd0);
        if (fuse_q[3:0] != 4'd0) begin
          cd_d  = sum_sat;
          run_d = (sum_sat != '0);
        end else begin
          cd_d  = '0;
          run_d = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fuse_q      <= '0;
      core_q      <= wwdt_pkg::CORE_W'(20000000);
      wdt_q       <= wwdt_pkg::WDT_W'(1024);
      ctrl_q      <= '0;
      lock_q      <= 1'b0;
      cd_q        <= '0;
      run_q       <= 1'b0;
      sync_q      <= '0;
      first_q     <= 1'b1;
      period_q    <= '0;
      window_q    <= '0;
      cache_ok_q  <= 1'b1;  // codes are off after reset, so both delays are zero
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          wwdt_pkg::CFG_FUSE: fuse_q <= cfg_wdata_i[wwdt_pkg::FUSE_W-1:0];
          wwdt_pkg::CFG_CORE: core_q <= cfg_wdata_i[wwdt_pkg::CORE_W-1:0];
          wwdt_pkg::CFG_WDT:  wdt_q  <= cfg_wdata_i[wwdt_pkg::WDT_W-1:0];
          default: ;
        endcase
      end
      if (cfg_we_i && ((cfg_idx_i == wwdt_pkg::CFG_CORE) ||
                       (cfg_idx_i == wwdt_pkg::CFG_WDT))) begin
        cache_ok_q <= 1'b0;
      end else if (cmd_i.save_w) begin
        cache_ok_q <= 1'b1;
      end
      if (cmd_i.save_p) begin
        period_q <= div_quot;
      end
      if (cmd_i.save_w) begin
        window_q <= div_quot;
      end
      if (cmd_i.exec) begin
        ctrl_q  <= ctrl_d;
        lock_q  <= lock_d;
        cd_q    <= cd_d;
        run_q   <= run_d;
        sync_q  <= sync_d;
        first_q <= first_d;
      end
      if (cmd_i.exec) begin
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      held_func_q <= func_i;
      held_data_q <= wdata_i;
    end
    if (cmd_i.exec) begin
      out_rd_q  <= rd_d;
      out_req_q <= req_d;
    end
  end

  assign m_tvalid_o = out_valid_q;
  assign rd_data_o  = out_rd_q;
  assign rst_req_o  = out_req_q;

endmodule

// ----- hdl/wwdt_ctrl.sv -----
// Controller: item acceptance and sequencing of the two delay divisions.
module wwdt_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_tvalid_i,
  input  wwdt_pkg::dp_status_t  status_i,
  output logic                  s_tready_o,
  output wwdt_pkg::dp_cmd_t     cmd_o
);

  wwdt_pkg::state_e state_q, state_d;
  logic             accept;

  assign accept = s_tvalid_i && (state_q == wwdt_pkg::ST_IDLE) && status_i.out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      wwdt_pkg::ST_IDLE: begin
        if (accept && status_i.need_div) begin
          state_d = wwdt_pkg::ST_DIV_P;
        end
      end
      wwdt_pkg::ST_DIV_P: begin
        if (!status_i.div_busy) begin
          state_d = wwdt_pkg::ST_DIV_W;
        end
      end
      wwdt_pkg::ST_DIV_W: begin
        if (!status_i.div_busy) begin
          state_d = wwdt_pkg::ST_EXEC;
        end
      end
      wwdt_pkg::ST_EXEC: begin
        if (status_i.out_free) begin
          state_d = wwdt_pkg::ST_IDLE;
        end
      end
      default: state_d = wwdt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    s_tready_o = 1'b0;
    case (state_q)
      wwdt_pkg::ST_IDLE: begin
        s_tready_o    = status_i.out_free;
        cmd_o.capture = accept;
        // items that need fresh delays start the period division first
        cmd_o.div_start = accept && status_i.need_div;
        cmd_o.exec      = accept && !status_i.need_div;
      end
      wwdt_pkg::ST_DIV_P: begin
        cmd_o.use_held  = 1'b1;
        cmd_o.div_win   = 1'b1;
        cmd_o.save_p    = !status_i.div_busy;
        cmd_o.div_start = !status_i.div_busy;
      end
      wwdt_pkg::ST_DIV_W: begin
        cmd_o.use_held = 1'b1;
        cmd_o.div_win  = 1'b1;
        cmd_o.save_w   = !status_i.div_busy;
      end
      wwdt_pkg::ST_EXEC: begin
        cmd_o.use_held = 1'b1;
        cmd_o.exec     = status_i.out_free;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wwdt_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ----- hdl/windowed_watchdog_timer_core.sv -----
// Items that use the cached delays execute on acceptance and load the output register.
// 1 item per cycle for ticks, clears, reads and status writes, unless m_tready stalls.
// Unlocked control writes, device resets and a tick ending a clear sync after a
// frequency change decode both delays in a one-bit-per-cycle divider, input held off.
// Reset: asynchronous active low; state clears, frequencies take their defaults.
module windowed_watchdog_timer_core #(
  parameter int COUNT_WIDTH = 32,
  parameter int SYNC_TICKS  = 3
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [1:0]                  cfg_idx_i,
  input  logic [wwdt_pkg::CFG_W-1:0]  cfg_wdata_i,
  input  logic                        s_tvalid_i,
  output logic                        s_tready_o,
  input  logic [7:0]                  s_tdata_i,   // [7:0] write_data
  input  logic [2:0]                  s_tuser_i,   // [2:0] func
  output logic                        m_tvalid_o,
  input  logic                        m_tready_i,
  output logic [15:0]                 m_tdata_o    // [7:0] read_data, [8] reset_request
);

  wwdt_pkg::dp_cmd_t    cmd;
  wwdt_pkg::dp_status_t status;
  logic [7:0]           rd_data;
  logic                 rst_req;

  wwdt_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .status_i   (status),
    .s_tready_o (s_tready_o),
    .cmd_o      (cmd)
  );

  wwdt_dp #(
    .COUNT_WIDTH (COUNT_WIDTH),
    .SYNC_TICKS  (SYNC_TICKS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .func_i      (s_tuser_i),
    .wdata_i     (s_tdata_i),
    .m_tready_i  (m_tready_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .m_tvalid_o  (m_tvalid_o),
    .rd_data_o   (rd_data),
    .rst_req_o   (rst_req)
  );

  assign m_tdata_o = {7'd0, rst_req, rd_data};

`ifndef ASSERT_OFF
  a_ready_not_dividing : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_tready_o |-> !status.div_busy)
    else $error("input ready while divider busy");

  a_fast_item_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_tvalid_i && s_tready_o && !status.need_div) |=> m_tvalid_o)
    else $error("no result after a single-cycle item");

  a_div_start_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.div_start |-> !status.div_busy)
    else $error("divider restarted while busy");
`endif

endmodule
